FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// shared constants, types and helpers of the quaternion unit
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 24;
  localparam int GUARD_BITS   = 4;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 34;
  localparam int ANGLE_SHIFT  = FRAC_BITS + 2;
  localparam int ISQRT_STEPS  = 32;
  localparam int LEN_W        = 33;
  localparam int QUO_W        = FRAC_BITS + 1;
  localparam int NUM_W        = WORD_W + FRAC_BITS;
  localparam int ML_W         = 25;
  localparam int AO_W         = 6;

  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [30:0] TWO32_OVER_PI = 31'd1367130551;

  localparam int QMUL_LAT   = 2;
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;
  localparam int EULER_LAT  = CORDIC_LAT + 3 * QMUL_LAT;
  localparam int NORM_LAT   = 4 + ISQRT_STEPS + QUO_W;

  localparam logic [2:0] FUNC_MUL    = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_SCALE  = 3'd2;
  localparam logic [2:0] FUNC_NORM   = 3'd3;
  localparam logic [2:0] FUNC_INVERT = 3'd4;
  localparam logic [2:0] FUNC_ANGLES = 3'd5;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_SKIP = 2'd3;

  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_AXIS_ORDER = 1'b1;

  localparam logic [ML_W-1:0] MIN_LENGTH_RESET = 25'd17;
  localparam logic [AO_W-1:0] AXIS_ORDER_RESET = 6'd6;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // index 0 is the real part, then i, j, k
  typedef logic [3:0][WORD_W-1:0] quat_t;

  typedef struct packed {
    quat_t q;
    logic  ovf;
    logic  too_short;
  } res_t;

  localparam quat_t QUAT_ONE = {{(3*WORD_W){1'b0}}, WORD_W'(1) << FRAC_BITS};

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [65:0] v);
    logic [WORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[WORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [65:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

  // arctangent of 2^-i in binary angle units
  function automatic logic [WORD_W-1:0] atan_turn(input int i);
    logic [WORD_W-1:0] r;
    unique case (i)
      0:  r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9:  r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic quat_t axis_quat(input logic [WORD_W-1:0] c,
                                      input logic [WORD_W-1:0] s,
                                      input logic [1:0] code);
    quat_t q;
    q = '0;
    q[0] = c;
    unique case (code)
      AXIS_X:  q[1] = s;
      AXIS_Y:  q[2] = s;
      AXIS_Z:  q[3] = s;
      default: q[0] = c;
    endcase
    return q;
  endfunction

endpackage

FILE: hdl/qau_qmul.sv
// ----------------------------------------------------------------------------
// qau_qmul
// two-stage hamilton product with guard-bit rounding and saturation
// ----------------------------------------------------------------------------
module qau_qmul import qau_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  quat_t a,
  input  quat_t b,
  output quat_t r,
  output logic  ovf
);

  localparam int PP_SHIFT = FRAC_BITS - GUARD_BITS;
  localparam logic signed [65:0] RND = 66'sd1 <<< (GUARD_BITS - 1);

  logic signed [63:0] pp [4][4];
  logic signed [65:0] s [4];
  logic signed [65:0] rnd [4];
  logic [3:0] hit;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp[i][j] <= ($signed(a[i]) * $signed(b[j])) >>> PP_SHIFT;
        end
      end
    end
  end

  always_comb begin
    s[0] = 66'(pp[0][0]) - 66'(pp[1][1]) - 66'(pp[2][2]) - 66'(pp[3][3]);
    s[1] = 66'(pp[0][1]) + 66'(pp[1][0]) + 66'(pp[2][3]) - 66'(pp[3][2]);
    s[2] = 66'(pp[0][2]) - 66'(pp[1][3]) + 66'(pp[2][0]) + 66'(pp[3][1]);
    s[3] = 66'(pp[0][3]) + 66'(pp[1][2]) - 66'(pp[2][1]) + 66'(pp[3][0]);
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (s[k] + RND) >>> GUARD_BITS;
      hit[k] = sat_hit(rnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r[k] <= sat_word(rnd[k]);
      end
      ovf <= |hit;
    end
  end

endmodule

FILE: hdl/qau_cordic.sv
// ----------------------------------------------------------------------------
// qau_cordic
// pipelined half-angle cosine and sine, one cordic step per stage
// ----------------------------------------------------------------------------
module qau_cordic import qau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] theta,
  output logic [WORD_W-1:0] cs,
  output logic [WORD_W-1:0] sn
);

  localparam logic signed [CORDIC_W-1:0] QUARTER   = 34'sd1 <<< 30;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd1 <<< 31;
  localparam int OUT_SHIFT = CORDIC_FRAC - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] OUT_RND = 34'sd1 <<< (OUT_SHIFT - 1);

  logic signed [62:0] prod;
  logic [WORD_W-1:0] ang;
  logic signed [CORDIC_W-1:0] zf;
  logic signed [CORDIC_W-1:0] zfold;
  logic nfold;
  logic signed [CORDIC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] zs [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] neg;
  logic signed [CORDIC_W-1:0] xf;
  logic signed [CORDIC_W-1:0] yf;
  logic signed [CORDIC_W-1:0] xr;
  logic signed [CORDIC_W-1:0] yr;

  assign prod = $signed(theta) * $signed({1'b0, TWO32_OVER_PI});

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= prod[ANGLE_SHIFT +: WORD_W];
    end
  end

  // fold into the right half plane
  always_comb begin
    zf = CORDIC_W'($signed(ang));
    zfold = zf;
    nfold = 1'b0;
    if (zf > QUARTER) begin
      zfold = zf - HALF_TURN;
      nfold = 1'b1;
    end else if (zf < -QUARTER) begin
      zfold = zf + HALF_TURN;
      nfold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= CORDIC_START;
      ys[0]  <= '0;
      zs[0]  <= zfold;
      neg[0] <= nfold;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (!zs[i][CORDIC_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - CORDIC_W'(atan_turn(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + CORDIC_W'(atan_turn(i));
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  always_comb begin
    xf = neg[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
    yf = neg[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    xr = (xf + OUT_RND) >>> OUT_SHIFT;
    yr = (yf + OUT_RND) >>> OUT_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= xr[WORD_W-1:0];
      sn <= yr[WORD_W-1:0];
    end
  end

endmodule

FILE: hdl/qau_euler.sv
// ----------------------------------------------------------------------------
// qau_euler
// three cordic lanes, then the axis rotations composed in configured order
// ----------------------------------------------------------------------------
module qau_euler import qau_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  quat_t           a,
  input  logic [AO_W-1:0] axis_order,
  output res_t            res
);

  logic [1:0] code [3];
  logic [2:0] skip;
  logic [WORD_W-1:0] theta [3];
  logic [WORD_W-1:0] cs [3];
  logic [WORD_W-1:0] sn [3];
  quat_t ax [3];
  quat_t ax1_d [2];
  quat_t ax2_d [4];
  quat_t m0;
  quat_t m1;
  quat_t m2;
  logic om0;
  logic om1;
  logic om2;
  quat_t r0;
  quat_t r1;
  logic o0;
  logic o1;
  quat_t r0_d [2];
  quat_t r1_d [2];
  logic [1:0] o0_d;
  logic [1:0] o1_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      code[l] = axis_order[2*l +: 2];
      skip[l] = (code[l] == AXIS_SKIP);
      unique case (code[l])
        AXIS_X:  theta[l] = a[1];
        AXIS_Y:  theta[l] = a[2];
        AXIS_Z:  theta[l] = a[3];
        default: theta[l] = '0;
      endcase
      ax[l] = axis_quat(cs[l], sn[l], code[l]);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    qau_cordic u_cordic (
      .clk   (clk),
      .en    (en),
      .theta (theta[l]),
      .cs    (cs[l]),
      .sn    (sn[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_d[0] <= ax[1];
      ax1_d[1] <= ax1_d[0];
      ax2_d[0] <= ax[2];
      for (int k = 1; k < 4; k++) begin
        ax2_d[k] <= ax2_d[k-1];
      end
      r0_d[0] <= r0;
      r0_d[1] <= r0_d[0];
      o0_d    <= {o0_d[0], o0};
      r1_d[0] <= r1;
      r1_d[1] <= r1_d[0];
      o1_d    <= {o1_d[0], o1};
    end
  end

  qau_qmul u_slot0 (.clk(clk), .en(en), .a(QUAT_ONE), .b(ax[0]), .r(m0), .ovf(om0));

  assign r0 = skip[0] ? QUAT_ONE : m0;
  assign o0 = !skip[0] && om0;

  qau_qmul u_slot1 (.clk(clk), .en(en), .a(r0), .b(ax1_d[1]), .r(m1), .ovf(om1));

  assign r1 = skip[1] ? r0_d[1] : m1;
  assign o1 = o0_d[1] || (!skip[1] && om1);

  qau_qmul u_slot2 (.clk(clk), .en(en), .a(r1), .b(ax2_d[3]), .r(m2), .ovf(om2));

  assign res.q         = skip[2] ? r1_d[1] : m2;
  assign res.ovf       = o1_d[1] || (!skip[2] && om2);
  assign res.too_short = 1'b0;

endmodule

FILE: hdl/qau_norm.sv
// ----------------------------------------------------------------------------
// qau_norm
// length by pipelined square root, then one divider lane per component
// ----------------------------------------------------------------------------
module qau_norm import qau_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [3:0][WORD_W:0]  v,
  input  logic [ML_W-1:0]       min_length,
  output res_t                  res
);

  typedef struct packed {
    logic [3:0][WORD_W-1:0] m;
    logic [3:0]             sg;
  } side_t;

  side_t side_in;
  side_t side1;
  side_t side_s [ISQRT_STEPS+1];
  side_t side_q [QUO_W+1];
  logic [63:0] sq [4];
  logic [65:0] sum;
  logic [63:0] rem_s [ISQRT_STEPS+1];
  logic [63:0] root_s [ISQRT_STEPS+1];
  logic [ISQRT_STEPS:0] cy_s;
  logic [63:0] trial [ISQRT_STEPS];
  logic [63:0] sq_bit [ISQRT_STEPS];
  logic [ISQRT_STEPS-1:0] take;
  logic [LEN_W-1:0] len;
  logic len_short;
  logic [NUM_W-1:0] drem [QUO_W+1][4];
  logic [QUO_W-1:0] quo [QUO_W+1][4];
  logic [LEN_W-1:0] den [QUO_W+1];
  logic [QUO_W:0] short_q;
  logic [NUM_W+1:0] cand [QUO_W];
  logic signed [WORD_W:0] vs [4];
  logic [3:0] hit;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      side_in.sg[k] = v[k][WORD_W];
      side_in.m[k]  = WORD_W'(v[k][WORD_W] ? -$signed(v[k]) : $signed(v[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq[k] <= side_in.m[k] * side_in.m[k];
      end
      side1 <= side_in;
    end
  end

  assign sum = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]) + 66'(sq[3]);

  always_comb begin
    for (int i = 0; i < ISQRT_STEPS; i++) begin
      sq_bit[i] = 64'd1 << (62 - 2 * i);
      trial[i]  = root_s[i] + sq_bit[i];
      take[i]   = rem_s[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= sum[63:0];
      root_s[0] <= '0;
      cy_s[0]   <= |sum[65:64];
      side_s[0] <= side1;
      for (int i = 0; i < ISQRT_STEPS; i++) begin
        if (take[i]) begin
          rem_s[i+1]  <= rem_s[i] - trial[i];
          root_s[i+1] <= (root_s[i] >> 1) + sq_bit[i];
        end else begin
          rem_s[i+1]  <= rem_s[i];
          root_s[i+1] <= root_s[i] >> 1;
        end
        cy_s[i+1]   <= cy_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  // a sum of 2^64 or more sets the carry, and its length is then taken as 2^32
  always_comb begin
    len = cy_s[ISQRT_STEPS] ? {1'b1, {(LEN_W-1){1'b0}}}
                            : {1'b0, root_s[ISQRT_STEPS][WORD_W-1:0]};
    len_short = len <= LEN_W'(min_length);
  end

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      cand[j] = (NUM_W + 2)'(den[j]) << (QUO_W - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        drem[0][k] <= (NUM_W'(side_s[ISQRT_STEPS].m[k]) << FRAC_BITS)
                      + NUM_W'(len >> 1);
        quo[0][k]  <= '0;
      end
      den[0]     <= len;
      short_q[0] <= len_short;
      side_q[0]  <= side_s[ISQRT_STEPS];
      for (int j = 0; j < QUO_W; j++) begin
        for (int k = 0; k < 4; k++) begin
          if ((NUM_W + 2)'(drem[j][k]) >= cand[j]) begin
            drem[j+1][k] <= drem[j][k] - cand[j][NUM_W-1:0];
            quo[j+1][k]  <= quo[j][k] | (QUO_W'(1) << (QUO_W - 1 - j));
          end else begin
            drem[j+1][k] <= drem[j][k];
            quo[j+1][k]  <= quo[j][k];
          end
        end
        den[j+1]     <= den[j];
        short_q[j+1] <= short_q[j];
        side_q[j+1]  <= side_q[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vs[k]  = side_q[QUO_W].sg[k] ? -$signed({1'b0, side_q[QUO_W].m[k]})
                                   : $signed({1'b0, side_q[QUO_W].m[k]});
      hit[k] = sat_hit(66'(vs[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        if (short_q[QUO_W]) begin
          res.q[k] <= sat_word(66'(vs[k]));
        end else if (side_q[QUO_W].sg[k]) begin
          res.q[k] <= WORD_W'(-$signed({1'b0, quo[QUO_W][k]}));
        end else begin
          res.q[k] <= WORD_W'(quo[QUO_W][k]);
        end
      end
      res.ovf       <= short_q[QUO_W] && (|hit);
      res.too_short <= short_q[QUO_W];
    end
  end

endmodule

FILE: hdl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// fixed-point quaternion product, sum, scale, normalize, invert and
// angles-to-quaternion, one operation chosen per item
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle while item_stall is low,
// and every operation is delayed to match the longest path, normalize and
// invert: a 32-stage square root for the length and a 25-stage divider lane
// for each component. The whole pipeline holds while a finished result
// waits under stall, so stall on the item side follows stall
// on the result side. Angles to quaternion runs three cordic lanes in
// parallel and composes the rotations in the order set by axis_order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [2:0]        func,
  input  logic [WORD_W-1:0] a_w,
  input  logic [WORD_W-1:0] a_x,
  input  logic [WORD_W-1:0] a_y,
  input  logic [WORD_W-1:0] a_z,
  input  logic [WORD_W-1:0] b_w,
  input  logic [WORD_W-1:0] b_x,
  input  logic [WORD_W-1:0] b_y,
  input  logic [WORD_W-1:0] b_z,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [WORD_W-1:0] r_w,
  output logic [WORD_W-1:0] r_x,
  output logic [WORD_W-1:0] r_y,
  output logic [WORD_W-1:0] r_z,
  output logic              overflow,
  output logic              too_short,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [ML_W-1:0]   cfg_data
);

  localparam logic signed [65:0] SCALE_RND = 66'sd1 <<< (FRAC_BITS - 1);

  logic en;
  logic [ML_W-1:0] min_length;
  logic [AO_W-1:0] axis_order;
  logic [NORM_LAT:1] vld;
  logic [2:0] func_d [1:NORM_LAT];
  quat_t qa;
  quat_t qb;
  logic [3:0][WORD_W:0] nv;
  quat_t mul_q;
  logic mul_ovf;
  logic signed [WORD_W:0] sum1 [4];
  logic signed [63:0] prod1 [4];
  logic signed [65:0] srnd [4];
  res_t add_r;
  res_t scale_r;
  res_t as_r;
  res_t fast_d [3:NORM_LAT];
  res_t eul_r;
  res_t eul_d [EULER_LAT+1:NORM_LAT];
  res_t norm_r;
  res_t out_r;

  assign en = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      axis_order <= AXIS_ORDER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH: min_length <= cfg_data;
        CFG_AXIS_ORDER: axis_order <= cfg_data[AO_W-1:0];
        default:        min_length <= min_length;
      endcase
    end
  end

  assign qa = {a_z, a_y, a_x, a_w};
  assign qb = {b_z, b_y, b_x, b_w};

  // conjugate for invert
  always_comb begin
    nv[0] = (WORD_W + 1)'($signed(a_w));
    for (int k = 1; k < 4; k++) begin
      nv[k] = (func == FUNC_INVERT) ? -(WORD_W + 1)'($signed(qa[k]))
                                    : (WORD_W + 1)'($signed(qa[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NORM_LAT-1:1], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_d[1] <= func;
      for (int k = 2; k <= NORM_LAT; k++) begin
        func_d[k] <= func_d[k-1];
      end
    end
  end

  qau_qmul u_mul (
    .clk (clk),
    .en  (en),
    .a   (qa),
    .b   (qb),
    .r   (mul_q),
    .ovf (mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sum1[k]  <= (WORD_W + 1)'($signed(qa[k])) + (WORD_W + 1)'($signed(qb[k]));
        prod1[k] <= $signed(qa[k]) * $signed(b_w);
      end
    end
  end

  always_comb begin
    add_r   = '0;
    scale_r = '0;
    for (int k = 0; k < 4; k++) begin
      srnd[k] = (66'(prod1[k]) + SCALE_RND) >>> FRAC_BITS;
      add_r.q[k]   = sat_word(66'(sum1[k]));
      scale_r.q[k] = sat_word(srnd[k]);
      add_r.ovf    = add_r.ovf | sat_hit(66'(sum1[k]));
      scale_r.ovf  = scale_r.ovf | sat_hit(srnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as_r <= (func_d[1] == FUNC_ADD) ? add_r : scale_r;
      if (func_d[2] == FUNC_MUL) begin
        fast_d[3] <= '{q: mul_q, ovf: mul_ovf, too_short: 1'b0};
      end else begin
        fast_d[3] <= as_r;
      end
      for (int k = 4; k <= NORM_LAT; k++) begin
        fast_d[k] <= fast_d[k-1];
      end
    end
  end

  qau_euler u_euler (
    .clk        (clk),
    .en         (en),
    .a          (qa),
    .axis_order (axis_order),
    .res        (eul_r)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      eul_d[EULER_LAT+1] <= eul_r;
      for (int k = EULER_LAT + 2; k <= NORM_LAT; k++) begin
        eul_d[k] <= eul_d[k-1];
      end
    end
  end

  qau_norm u_norm (
    .clk        (clk),
    .en         (en),
    .v          (nv),
    .min_length (min_length),
    .res        (norm_r)
  );

  // merge the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld[NORM_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (func_d[NORM_LAT])
        FUNC_MUL, FUNC_ADD, FUNC_SCALE: out_r <= fast_d[NORM_LAT];
        FUNC_NORM, FUNC_INVERT:         out_r <= norm_r;
        FUNC_ANGLES:                    out_r <= eul_d[NORM_LAT];
        default:                        out_r <= '0;
      endcase
    end
  end

  assign r_w       = out_r.q[0];
  assign r_x       = out_r.q[1];
  assign r_y       = out_r.q[2];
  assign r_z       = out_r.q[3];
  assign overflow  = out_r.ovf;
  assign too_short = out_r.too_short;

  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !result_valid, !item_stall)
  `ASSERT_NEXT(a_deliver, clk, rst, vld[NORM_LAT] && !item_stall, result_valid)
  `ASSERT_NEXT(a_pipe_frozen, clk, rst, item_stall, $stable(vld))
  `ASSERT_IMPL(a_short_no_sat, clk, rst, result_valid && too_short, !overflow)

endmodule
